// File: design/bsr_pkg.sv
package bsr_pkg;

	localparam int REQUEST_LENGTH_DEF = 9;
	localparam int SERIES_CELLS_DEF   = 10;

	localparam int BYTE_W  = 8;
	localparam int ADC_W   = 10;
	localparam int ADC_BITS = ADC_W;
	localparam int CAP_W   = 16;
	localparam int LIM_W   = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W   = 16;
	localparam int SMOOTH_W = 24;
	localparam int POS_W   = 4;
	localparam int IDX_W   = 6;
	localparam int SUM_W   = 16;
	localparam int PCT_W   = 7;
	localparam int DIV_NW  = 24;
	localparam int DIV_DW  = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_PACK_CAPACITY   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_LIMIT = 1'b1;

	localparam logic [CAP_W-1:0] PACK_CAPACITY_RST   = 16'd6600;
	localparam logic [LIM_W-1:0] SMOOTHING_LIMIT_RST = 7'd10;

	localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h55;
	localparam logic [BYTE_W-1:0] CMD_SERIAL  = 8'h10;
	localparam logic [BYTE_W-1:0] CMD_CYCLES  = 8'h1B;
	localparam logic [BYTE_W-1:0] CMD_DATE    = 8'h20;
	localparam logic [BYTE_W-1:0] CMD_STAT30  = 8'h30;
	localparam logic [BYTE_W-1:0] CMD_STAT31  = 8'h31;
	localparam logic [BYTE_W-1:0] CMD_PING    = 8'h3B;
	localparam logic [BYTE_W-1:0] CMD_CELLS   = 8'h40;
	localparam logic [BYTE_W-1:0] SUB_SHORT_SERIAL = 8'h10;
	localparam logic [BYTE_W-1:0] SERIAL_EXT_LEN   = 8'h14;

	localparam logic [12:0] VOLT_SCALE = 13'd5610;
	localparam logic [SUM_W-1:0] CRC_BASE = 16'hFFFF;
	localparam logic [PCT_W-1:0] PCT_DIV = 7'd100;
	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

	localparam logic [15:0] BP_CELL [7] = '{16'd250, 16'd285, 16'd310, 16'd333,
		16'd348, 16'd402, 16'd415};
	localparam logic [PCT_W-1:0] BP_PCT [7] = '{7'd0, 7'd5, 7'd10, 7'd20, 7'd30,
		7'd90, 7'd100};

	localparam int TPL_DEPTH = 92;
	localparam logic [BYTE_W-1:0] TPL_ROM [TPL_DEPTH] = '{
		8'h55,8'hAA,8'h12,8'h25,8'h01,8'h10,8'h2A,8'h59,8'h41,8'h45,8'h42,8'h4C,
		8'h41,8'h4E,8'h20,8'h63,8'h3D,8'h3D,8'h33,8'h2A,8'h00,8'h02,
		8'h55,8'hAA,8'h06,8'h25,8'h01,8'h1B,8'h01,8'h00,8'h01,8'h00,
		8'h55,8'hAA,8'h08,8'h25,8'h01,8'h20,8'h87,8'h25,8'h00,8'h00,8'h00,8'h00,
		8'h55,8'hAA,8'h0E,8'h25,8'h01,8'h30,8'h01,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h10,8'h00,8'h00,8'h00,8'h2A,8'h2B,
		8'h55,8'hAA,8'h0C,8'h25,8'h01,8'h31,8'h00,8'h00,8'h00,8'h00,8'h10,8'h00,
		8'h00,8'h00,8'h2A,8'h2B,
		8'h55,8'hAA,8'h04,8'h25,8'h01,8'h3B,8'h62,8'h00,
		8'h55,8'hAA,8'h20,8'h25,8'h01,8'h40};

	typedef enum logic [2:0] {
		KIND_NONE, KIND_SERIAL, KIND_CYCLES, KIND_DATE,
		KIND_STAT30, KIND_STAT31, KIND_PING, KIND_CELLS
	} kind_t;

	typedef enum logic [1:0] {OP_VOLT, OP_AVG, OP_PCT, OP_REM} div_op_t;

	typedef enum logic [3:0] {
		S_IDLE, S_VOLT_GO, S_VOLT, S_AVG_GO, S_AVG, S_PCT_GO, S_PCT,
		S_REM_GO, S_REM, S_EMIT
	} state_t;

	typedef struct packed {
		logic    take;
		logic    div_start;
		logic    div_latch;
		div_op_t div_op;
		logic    frame_start;
		logic    emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic  req_final;
		kind_t kind;
		logic  div_done;
		logic  out_free;
		logic  emit_last;
	} dp_stat_t;

	function automatic kind_t cmd_kind(input logic [BYTE_W-1:0] c);
		case (c)
			CMD_SERIAL: cmd_kind = KIND_SERIAL;
			CMD_CYCLES: cmd_kind = KIND_CYCLES;
			CMD_DATE:   cmd_kind = KIND_DATE;
			CMD_STAT30: cmd_kind = KIND_STAT30;
			CMD_STAT31: cmd_kind = KIND_STAT31;
			CMD_PING:   cmd_kind = KIND_PING;
			CMD_CELLS:  cmd_kind = KIND_CELLS;
			default:    cmd_kind = KIND_NONE;
		endcase
	endfunction

	function automatic logic [6:0] tpl_base(input kind_t k);
		case (k)
			KIND_SERIAL: tpl_base = 7'd0;
			KIND_CYCLES: tpl_base = 7'd22;
			KIND_DATE:   tpl_base = 7'd32;
			KIND_STAT30: tpl_base = 7'd44;
			KIND_STAT31: tpl_base = 7'd62;
			KIND_PING:   tpl_base = 7'd78;
			KIND_CELLS:  tpl_base = 7'd86;
			default:     tpl_base = 7'd0;
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] frame_len(input kind_t k, input logic ext);
		case (k)
			KIND_SERIAL: frame_len = ext ? 6'd24 : 6'd22;
			KIND_CYCLES: frame_len = 6'd10;
			KIND_DATE:   frame_len = 6'd12;
			KIND_STAT30: frame_len = 6'd18;
			KIND_STAT31: frame_len = 6'd16;
			KIND_PING:   frame_len = 6'd8;
			KIND_CELLS:  frame_len = 6'd36;
			default:     frame_len = 6'd0;
		endcase
	endfunction

endpackage

// File: design/bsr_in_if.sv
interface bsr_in_if;
	logic                       valid;
	logic                       ready;
	logic [bsr_pkg::BYTE_W-1:0] rx_byte;
	logic [bsr_pkg::ADC_W-1:0]  adc_sample;

	modport source (output valid, output rx_byte, output adc_sample, input ready);
	modport sink (input valid, input rx_byte, input adc_sample, output ready);
endinterface

// File: design/bsr_out_if.sv
interface bsr_out_if;
	logic                       valid;
	logic                       ready;
	logic [bsr_pkg::BYTE_W-1:0] tx_byte;
	logic                       last_byte;

	modport source (output valid, output tx_byte, output last_byte, input ready);
	modport sink (input valid, input tx_byte, input last_byte, output ready);
endinterface

// File: design/bsr_div.sv
module bsr_div #(
	parameter int NW = bsr_pkg::DIV_NW,
	parameter int DW = bsr_pkg::DIV_DW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);
	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], fits};
			rem_q <= fits ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// File: design/bsr_ctrl.sv
module bsr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bsr_pkg::dp_stat_t   stat,
	output bsr_pkg::ctrl_cmd_t  cmd
);
	bsr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		in_ready        = 1'b0;
		cmd.take        = 1'b0;
		cmd.div_start   = 1'b0;
		cmd.div_latch   = 1'b0;
		cmd.div_op      = bsr_pkg::OP_VOLT;
		cmd.frame_start = 1'b0;
		cmd.emit        = 1'b0;
		case (state_q)
			bsr_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					if (stat.req_final) begin
						case (stat.kind)
							bsr_pkg::KIND_NONE: state_d = bsr_pkg::S_IDLE;
							bsr_pkg::KIND_STAT30, bsr_pkg::KIND_STAT31,
							bsr_pkg::KIND_CELLS: state_d = bsr_pkg::S_VOLT_GO;
							default: begin
								cmd.frame_start = 1'b1;
								state_d = bsr_pkg::S_EMIT;
							end
						endcase
					end
				end
			end
			bsr_pkg::S_VOLT_GO: begin
				cmd.div_start = 1'b1;
				state_d = bsr_pkg::S_VOLT;
			end
			bsr_pkg::S_VOLT: begin
				cmd.div_latch = stat.div_done;
				if (stat.div_done) begin
					if (stat.kind == bsr_pkg::KIND_CELLS) begin
						cmd.frame_start = 1'b1;
						state_d = bsr_pkg::S_EMIT;
					end else begin
						state_d = bsr_pkg::S_AVG_GO;
					end
				end
			end
			bsr_pkg::S_AVG_GO: begin
				cmd.div_op    = bsr_pkg::OP_AVG;
				cmd.div_start = 1'b1;
				state_d = bsr_pkg::S_AVG;
			end
			bsr_pkg::S_AVG: begin
				cmd.div_op    = bsr_pkg::OP_AVG;
				cmd.div_latch = stat.div_done;
				if (stat.div_done) state_d = bsr_pkg::S_PCT_GO;
			end
			bsr_pkg::S_PCT_GO: begin
				cmd.div_op    = bsr_pkg::OP_PCT;
				cmd.div_start = 1'b1;
				state_d = bsr_pkg::S_PCT;
			end
			bsr_pkg::S_PCT: begin
				cmd.div_op    = bsr_pkg::OP_PCT;
				cmd.div_latch = stat.div_done;
				if (stat.div_done) state_d = bsr_pkg::S_REM_GO;
			end
			bsr_pkg::S_REM_GO: begin
				cmd.div_op    = bsr_pkg::OP_REM;
				cmd.div_start = 1'b1;
				state_d = bsr_pkg::S_REM;
			end
			bsr_pkg::S_REM: begin
				cmd.div_op    = bsr_pkg::OP_REM;
				cmd.div_latch = stat.div_done;
				if (stat.div_done) begin
					cmd.frame_start = 1'b1;
					state_d = bsr_pkg::S_EMIT;
				end
			end
			bsr_pkg::S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.emit_last) state_d = bsr_pkg::S_IDLE;
				end
			end
			default: state_d = bsr_pkg::S_IDLE;
		endcase
	end
endmodule

// File: design/bsr_dp.sv
module bsr_dp #(
	parameter int REQUEST_LENGTH = bsr_pkg::REQUEST_LENGTH_DEF,
	parameter int SERIES_CELLS   = bsr_pkg::SERIES_CELLS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bsr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bsr_pkg::CFG_W-1:0]       cfg_data,
	input  logic [bsr_pkg::BYTE_W-1:0]      rx_byte,
	input  logic [bsr_pkg::ADC_W-1:0]       adc_sample,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [bsr_pkg::BYTE_W-1:0]      tx_byte,
	output logic                            last_byte,
	input  bsr_pkg::ctrl_cmd_t              cmd,
	output bsr_pkg::dp_stat_t               stat
);
	localparam int NW = bsr_pkg::DIV_NW;
	localparam int DW = bsr_pkg::DIV_DW;
	localparam logic [bsr_pkg::ADC_W-1:0] ADC_FULL =
		bsr_pkg::ADC_W'((1 << bsr_pkg::ADC_BITS) - 1);
	localparam int VOLT_NUM = int'(bsr_pkg::VOLT_SCALE) * 256;
	localparam logic [20:0] VOLT_QUO = 21'(VOLT_NUM / int'(ADC_FULL));
	localparam logic [9:0] VOLT_FRAC = 10'(VOLT_NUM % int'(ADC_FULL));
	localparam int RCP_SH = 30;
	localparam logic [20:0] VOLT_RCP = 21'(((longint'(1) << RCP_SH) +
		longint'(ADC_FULL) - 1) / longint'(ADC_FULL));
	localparam logic [23:0] PCT_RCP = 24'(((longint'(1) << RCP_SH) +
		longint'(bsr_pkg::PCT_DIV) - 1) / longint'(bsr_pkg::PCT_DIV));
	localparam logic [bsr_pkg::POS_W-1:0] POS_FINAL = bsr_pkg::POS_W'(REQUEST_LENGTH - 1);
	localparam logic [bsr_pkg::POS_W-1:0] POS_CMD = 4'd5;
	localparam logic [bsr_pkg::POS_W-1:0] POS_SUB = 4'd6;

	logic [bsr_pkg::CAP_W-1:0]    cap_q;
	logic [bsr_pkg::LIM_W-1:0]    lim_q;
	logic [bsr_pkg::POS_W-1:0]    pos_q;
	logic [bsr_pkg::BYTE_W-1:0]   command_q;
	logic [bsr_pkg::BYTE_W-1:0]   subcode_q;
	logic [bsr_pkg::SMOOTH_W-1:0] smooth_q;
	logic [bsr_pkg::LIM_W-1:0]    divsr_q;
	logic [bsr_pkg::ADC_W-1:0]    adc_q;
	logic [bsr_pkg::SMOOTH_W-1:0] vfx_q;
	logic [bsr_pkg::PCT_W-1:0]    pct_q;
	logic [15:0]                  rem_q;
	logic [bsr_pkg::IDX_W-1:0]    idx_q;
	logic [bsr_pkg::SUM_W-1:0]    sum_q;
	logic                         out_valid_q;
	logic [bsr_pkg::BYTE_W-1:0]   tx_q;
	logic                         last_q;
	logic [22:0]                  cprod_s1;
	logic [20:0]                  vbase_s1;
	logic                         cvld_s1;
	logic                         cvld_s2;
	logic [16:0]                  cquo_s2;

	bsr_pkg::kind_t             kind;
	logic                       ext;
	logic [bsr_pkg::IDX_W-1:0]  len;
	logic [bsr_pkg::ADC_W-1:0]  adc_m;
	logic [24:0]                diff;
	logic                       neg;
	logic [bsr_pkg::SMOOTH_W-1:0] mag;
	logic [bsr_pkg::LIM_W-1:0]  kdiv;
	logic [15:0]                vbat;
	logic [15:0]                raw;
	logic [15:0]                seg_lo;
	logic [15:0]                seg_span;
	logic [bsr_pkg::PCT_W-1:0]  seg_base;
	logic [bsr_pkg::PCT_W-1:0]  seg_step;
	logic                       seg_hit;
	logic                       pct_low;
	logic                       pct_high;
	logic [15:0]                lo_i;
	logic [15:0]                hi_i;
	logic [22:0]                pct_prod;
	logic [22:0]                cap_prod;
	logic                       const_op;
	logic                       div_go;
	logic [23:0]                crcp;
	logic [46:0]                cfull;
	logic [NW-1:0]              dividend;
	logic [DW-1:0]              divisor;
	logic                       div_done;
	logic [NW-1:0]              quotient;
	logic [6:0]                 rom_addr;
	logic [bsr_pkg::BYTE_W-1:0] fbyte;
	logic [bsr_pkg::BYTE_W-1:0] obyte;
	logic                       olast;
	logic [bsr_pkg::SUM_W-1:0]  crc;

	assign kind = bsr_pkg::cmd_kind(command_q);
	assign ext  = subcode_q != bsr_pkg::SUB_SHORT_SERIAL;
	assign len  = bsr_pkg::frame_len(kind, ext);

	assign adc_m = adc_q & ADC_FULL;
	assign diff  = {1'b0, smooth_q} - {1'b0, vfx_q};
	assign neg   = diff[24];
	assign mag   = neg ? 24'(-diff) : diff[23:0];
	assign kdiv  = (divsr_q == '0) ? 7'd1 : divsr_q;
	assign vbat  = smooth_q[23:8];
	assign raw   = vfx_q[23:8];

	always_comb begin
		seg_hit  = 1'b0;
		seg_lo   = '0;
		seg_span = 16'd1;
		seg_base = '0;
		seg_step = '0;
		lo_i     = '0;
		hi_i     = '0;
		for (int i = 0; i < 6; i++) begin
			lo_i = 16'(bsr_pkg::BP_CELL[i] * SERIES_CELLS);
			hi_i = 16'(bsr_pkg::BP_CELL[i+1] * SERIES_CELLS);
			if (!seg_hit && vbat > lo_i && vbat <= hi_i) begin
				seg_hit  = 1'b1;
				seg_lo   = lo_i;
				seg_span = hi_i - lo_i;
				seg_base = bsr_pkg::BP_PCT[i];
				seg_step = bsr_pkg::BP_PCT[i+1] - bsr_pkg::BP_PCT[i];
			end
		end
	end

	assign pct_low  = vbat <= 16'(bsr_pkg::BP_CELL[0] * SERIES_CELLS);
	assign pct_high = vbat > 16'(bsr_pkg::BP_CELL[6] * SERIES_CELLS);
	assign pct_prod = seg_step * (vbat - seg_lo);
	assign cap_prod = cap_q * pct_q;

	assign const_op = (cmd.div_op == bsr_pkg::OP_VOLT) || (cmd.div_op == bsr_pkg::OP_REM);
	assign div_go   = cmd.div_start && !const_op;
	assign crcp     = (cmd.div_op == bsr_pkg::OP_VOLT) ? {3'b0, VOLT_RCP} : PCT_RCP;
	assign cfull    = {24'b0, cprod_s1} * {23'b0, crcp};

	always_comb begin
		case (cmd.div_op)
			bsr_pkg::OP_AVG: begin
				dividend = mag;
				divisor  = {9'b0, kdiv};
			end
			bsr_pkg::OP_PCT: begin
				dividend = {1'b0, pct_prod};
				divisor  = seg_span;
			end
			default: begin
				dividend = '0;
				divisor  = {{(DW-1){1'b0}}, 1'b1};
			end
		endcase
	end

	bsr_div #(.NW(NW), .DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= bsr_pkg::PACK_CAPACITY_RST;
			lim_q     <= bsr_pkg::SMOOTHING_LIMIT_RST;
			pos_q     <= '0;
			command_q <= '0;
			subcode_q <= '0;
			smooth_q  <= '0;
			divsr_q   <= 7'd1;
			out_valid_q <= 1'b0;
			cvld_s1   <= 1'b0;
			cvld_s2   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					bsr_pkg::CFG_PACK_CAPACITY:   cap_q <= cfg_data;
					bsr_pkg::CFG_SMOOTHING_LIMIT: lim_q <= cfg_data[bsr_pkg::LIM_W-1:0];
					default: ;
				endcase
			end
			if (cmd.take) begin
				if (pos_q == '0) begin
					if (rx_byte == bsr_pkg::HEADER_BYTE) pos_q <= 4'd1;
				end else begin
					if (pos_q == POS_CMD) command_q <= rx_byte;
					if (pos_q == POS_SUB) subcode_q <= rx_byte;
					pos_q <= (pos_q == POS_FINAL) ? '0 : pos_q + 4'd1;
				end
			end
			if (cmd.div_latch && cmd.div_op == bsr_pkg::OP_AVG) begin
				smooth_q <= neg ? smooth_q + quotient : smooth_q - quotient;
				if (divsr_q < lim_q) divsr_q <= divsr_q + 7'd1;
			end
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			cvld_s1 <= cmd.div_start && const_op;
			cvld_s2 <= cvld_s1;
		end
	end

	assign rom_addr = bsr_pkg::tpl_base(kind) + {1'b0, idx_q};

	always_comb begin
		fbyte = (rom_addr < 7'(bsr_pkg::TPL_DEPTH)) ? bsr_pkg::TPL_ROM[rom_addr] : '0;
		case (kind)
			bsr_pkg::KIND_SERIAL: begin
				if (ext && idx_q == 6'd2) fbyte = bsr_pkg::SERIAL_EXT_LEN;
				if (idx_q == 6'd22) fbyte = cap_q[7:0];
				if (idx_q == 6'd23) fbyte = cap_q[15:8];
			end
			bsr_pkg::KIND_STAT30: begin
				if (idx_q == 6'd8)  fbyte = rem_q[7:0];
				if (idx_q == 6'd9)  fbyte = rem_q[15:8];
				if (idx_q == 6'd10) fbyte = {1'b0, pct_q};
				if (idx_q == 6'd14) fbyte = vbat[7:0];
				if (idx_q == 6'd15) fbyte = vbat[15:8];
			end
			bsr_pkg::KIND_STAT31: begin
				if (idx_q == 6'd6)  fbyte = rem_q[7:0];
				if (idx_q == 6'd7)  fbyte = rem_q[15:8];
				if (idx_q == 6'd8)  fbyte = {1'b0, pct_q};
				if (idx_q == 6'd12) fbyte = vbat[7:0];
				if (idx_q == 6'd13) fbyte = vbat[15:8];
			end
			bsr_pkg::KIND_CELLS: begin
				if (idx_q >= 6'd6) fbyte = idx_q[0] ? raw[15:8] : raw[7:0];
			end
			default: ;
		endcase
	end

	assign crc = bsr_pkg::CRC_BASE - sum_q;

	always_comb begin
		if (idx_q < len) begin
			obyte = fbyte;
			olast = 1'b0;
		end else if (idx_q == len) begin
			obyte = crc[7:0];
			olast = 1'b0;
		end else begin
			obyte = crc[15:8];
			olast = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) adc_q <= adc_sample;
		if (cmd.div_start && const_op) begin
			cprod_s1 <= (cmd.div_op == bsr_pkg::OP_VOLT) ?
				({13'b0, adc_m} * {13'b0, VOLT_FRAC}) : cap_prod;
			vbase_s1 <= {11'b0, adc_m} * VOLT_QUO;
		end
		if (cvld_s1) cquo_s2 <= cfull[RCP_SH+16:RCP_SH];
		if (cmd.div_latch) begin
			case (cmd.div_op)
				bsr_pkg::OP_VOLT: vfx_q <= {3'b0, vbase_s1} + {7'b0, cquo_s2};
				bsr_pkg::OP_PCT: begin
					if (pct_low) pct_q <= '0;
					else if (pct_high || !seg_hit) pct_q <= bsr_pkg::PCT_FULL;
					else pct_q <= seg_base + quotient[bsr_pkg::PCT_W-1:0];
				end
				bsr_pkg::OP_REM: rem_q <= cquo_s2[15:0];
				default: ;
			endcase
		end
		if (cmd.frame_start) begin
			idx_q <= '0;
			sum_q <= '0;
		end else if (cmd.emit) begin
			idx_q <= idx_q + 6'd1;
			if (idx_q >= 6'd2 && idx_q < len) sum_q <= sum_q + {8'b0, fbyte};
		end
		if (cmd.emit) begin
			tx_q   <= obyte;
			last_q <= olast;
		end
	end

	assign stat.req_final = (pos_q != '0) && (pos_q == POS_FINAL);
	assign stat.kind      = kind;
	assign stat.div_done  = const_op ? cvld_s2 : div_done;
	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.emit_last = idx_q == len + 6'd1;

	assign out_valid = out_valid_q;
	assign tx_byte   = tx_q;
	assign last_byte = last_q;
endmodule

// File: design/battery_status_responder_core.sv
// channel  dir  payload                 request accepted when
// in_ch    in   rx_byte, adc_sample     valid && ready
// out_ch   out  tx_byte, last_byte      valid && ready
// cfg      in   cfg_index, cfg_data     cfg_we
//
// A request byte that does not end a request is taken while idle and only updates the parser.
// The final byte of a status request runs a voltage scaling step, two passes
// of the shared divider (average, percent) and a capacity step, in that order;
// a cell request runs the voltage step only.
// Response bytes then leave one per cycle while the output accepts them, len + 2 bytes.
// Reset is asynchronous and needs no sweep; a stalled output holds its byte.
module battery_status_responder_core #(
	parameter int REQUEST_LENGTH = bsr_pkg::REQUEST_LENGTH_DEF,
	parameter int SERIES_CELLS   = bsr_pkg::SERIES_CELLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	bsr_in_if.sink                        in_ch,
	bsr_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [bsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bsr_pkg::CFG_W-1:0]     cfg_data
);
	bsr_pkg::ctrl_cmd_t cmd;
	bsr_pkg::dp_stat_t  stat;

	bsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bsr_dp #(
		.REQUEST_LENGTH (REQUEST_LENGTH),
		.SERIES_CELLS   (SERIES_CELLS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.rx_byte    (in_ch.rx_byte),
		.adc_sample (in_ch.adc_sample),
		.out_ready  (out_ch.ready),
		.out_valid  (out_ch.valid),
		.tx_byte    (out_ch.tx_byte),
		.last_byte  (out_ch.last_byte),
		.cmd        (cmd),
		.stat       (stat)
	);
endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
	import bsr_pkg::*;

	typedef struct {
		logic [7:0] tx;
		logic       last;
	} tx_beat_t;

	localparam logic [7:0] SERIAL_T [22] = '{8'h55, 8'hAA, 8'h12, 8'h25, 8'h01, 8'h10,
		8'h2A, 8'h59, 8'h41, 8'h45, 8'h42, 8'h4C, 8'h41, 8'h4E, 8'h20, 8'h63, 8'h3D,
		8'h3D, 8'h33, 8'h2A, 8'h00, 8'h02};
	localparam logic [7:0] CYCLES_T [10] = '{8'h55, 8'hAA, 8'h06, 8'h25, 8'h01, 8'h1B,
		8'h01, 8'h00, 8'h01, 8'h00};
	localparam logic [7:0] DATE_T [12] = '{8'h55, 8'hAA, 8'h08, 8'h25, 8'h01, 8'h20,
		8'h87, 8'h25, 8'h00, 8'h00, 8'h00, 8'h00};
	localparam logic [7:0] STAT30_T [18] = '{8'h55, 8'hAA, 8'h0E, 8'h25, 8'h01, 8'h30,
		8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00, 8'h2A,
		8'h2B};
	localparam logic [7:0] STAT31_T [16] = '{8'h55, 8'hAA, 8'h0C, 8'h25, 8'h01, 8'h31,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00, 8'h2A, 8'h2B};
	localparam logic [7:0] PING_T [8] = '{8'h55, 8'hAA, 8'h04, 8'h25, 8'h01, 8'h3B,
		8'h62, 8'h00};
	localparam logic [7:0] CELLS_T [6] = '{8'h55, 8'hAA, 8'h20, 8'h25, 8'h01, 8'h40};
	localparam int unsigned KNEE_CELL [7] = '{250, 285, 310, 333, 348, 402, 415};
	localparam int unsigned KNEE_PCT [7] = '{0, 5, 10, 20, 30, 90, 100};
	localparam int CELLS = 10;
	localparam int REQ_LEN = 9;
	localparam int LIMIT_CYCLES = 600000;

	class response_tracker;
		logic [15:0] capacity;
		logic [6:0]  avg_limit;
		logic [3:0]  position;
		logic [7:0]  command;
		logic [7:0]  subcode;
		logic [23:0] avg_volt;
		logic [6:0]  avg_div;
		logic [7:0]  frame [36];
		tx_beat_t    pending_bytes [$];
		int          errors;

		function new();
			capacity  = PACK_CAPACITY_RST;
			avg_limit = SMOOTHING_LIMIT_RST;
			position  = 0;
			command   = 0;
			subcode   = 0;
			avg_volt  = 0;
			avg_div   = 1;
			errors    = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx == CFG_PACK_CAPACITY) capacity = data;
			else avg_limit = data[6:0];
		endfunction

		function longint volt_fx(logic [9:0] adc);
			return (longint'(adc) * 5610 * 256) / 1023;
		endfunction

		function int unsigned percent_of(int unsigned v);
			int unsigned lo;
			int unsigned hi;
			if (v <= KNEE_CELL[0] * CELLS) return 0;
			if (v > KNEE_CELL[6] * CELLS) return 100;
			for (int i = 0; i < 6; i++) begin
				lo = KNEE_CELL[i] * CELLS;
				hi = KNEE_CELL[i + 1] * CELLS;
				if (v > lo && v <= hi)
					return KNEE_PCT[i] + ((KNEE_PCT[i + 1] - KNEE_PCT[i]) * (v - lo)) / (hi - lo);
			end
			return 100;
		endfunction

		function void fill_status(int cap_at, int pct_at, int volt_at, logic [9:0] adc);
			longint      diff;
			longint      k;
			int unsigned vbat;
			int unsigned pct;
			int unsigned rem;
			diff = longint'(avg_volt) - volt_fx(adc);
			k = (avg_div != 0) ? longint'(avg_div) : 1;
			avg_volt = 24'(longint'(avg_volt) - diff / k);
			if (avg_div < avg_limit) avg_div = avg_div + 1;
			vbat = avg_volt[23:8];
			pct = percent_of(vbat);
			rem = (int'(capacity) * pct) / 100;
			frame[cap_at]      = rem[7:0];
			frame[cap_at + 1]  = rem[15:8];
			frame[pct_at]      = pct[7:0];
			frame[volt_at]     = vbat[7:0];
			frame[volt_at + 1] = vbat[15:8];
		endfunction

		function void take_request_byte(logic [7:0] b, logic [9:0] adc);
			int          len;
			logic [15:0] raw;
			logic [15:0] sum;
			if (position == 0) begin
				if (b == HEADER_BYTE) position = 1;
				return;
			end
			if (position == 5) command = b;
			if (position == 6) subcode = b;
			if (position + 1 < REQ_LEN) begin
				position = position + 1;
				return;
			end
			position = 0;
			case (command)
				CMD_SERIAL: begin
					for (int i = 0; i < 22; i++) frame[i] = SERIAL_T[i];
					len = 22;
					if (subcode != SUB_SHORT_SERIAL) begin
						frame[2]  = SERIAL_EXT_LEN;
						frame[22] = capacity[7:0];
						frame[23] = capacity[15:8];
						len = 24;
					end
				end
				CMD_CYCLES: begin
					for (int i = 0; i < 10; i++) frame[i] = CYCLES_T[i];
					len = 10;
				end
				CMD_DATE: begin
					for (int i = 0; i < 12; i++) frame[i] = DATE_T[i];
					len = 12;
				end
				CMD_STAT30: begin
					for (int i = 0; i < 18; i++) frame[i] = STAT30_T[i];
					len = 18;
					fill_status(8, 10, 14, adc);
				end
				CMD_STAT31: begin
					for (int i = 0; i < 16; i++) frame[i] = STAT31_T[i];
					len = 16;
					fill_status(6, 8, 12, adc);
				end
				CMD_PING: begin
					for (int i = 0; i < 8; i++) frame[i] = PING_T[i];
					len = 8;
				end
				CMD_CELLS: begin
					raw = 16'(volt_fx(adc) >> 8);
					for (int i = 0; i < 6; i++) frame[i] = CELLS_T[i];
					for (int i = 0; i < 15; i++) begin
						frame[6 + i * 2] = raw[7:0];
						frame[7 + i * 2] = raw[15:8];
					end
					len = 36;
				end
				default: return;
			endcase
			sum = 0;
			for (int i = 0; i < len; i++) begin
				if (i >= 2) sum = sum + frame[i];
				pending_bytes.push_back('{frame[i], 1'b0});
			end
			sum = 16'hFFFF - sum;
			pending_bytes.push_back('{sum[7:0], 1'b0});
			pending_bytes.push_back('{sum[15:8], 1'b1});
		endfunction

		function void check_tx_byte(logic [7:0] tx, logic last);
			tx_beat_t want;
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected byte tx=%02h last=%0b", $time, tx, last);
				errors++;
				return;
			end
			want = pending_bytes.pop_front();
			if (tx !== want.tx) begin
				$display("%0t: tx_byte expected %02h actual %02h", $time, want.tx, tx);
				errors++;
			end
			if (last !== want.last) begin
				$display("%0t: last_byte expected %0b actual %0b", $time, want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	int send_idle;
	int recv_stall;
	int cycles;
	response_tracker track;

	bsr_in_if in_ch ();
	bsr_out_if out_ch ();

	battery_status_responder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("battery_status_responder_core: mismatch");
				$finish;
			end
		end
	end

	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready = ($urandom_range(99) >= recv_stall);
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready)
				track.check_tx_byte(out_ch.tx_byte, out_ch.last_byte);
		end
	end

	task automatic send_item(logic [7:0] b, logic [9:0] adc);
		if ($urandom_range(99) < send_idle) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
			repeat ($urandom_range(2)) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.rx_byte = b;
		in_ch.adc_sample = adc;
		do @(posedge clk); while (!in_ch.ready);
		track.take_request_byte(b, adc);
	endtask

	task automatic send_request(logic [7:0] cmd, logic [7:0] sub, logic [9:0] adc);
		send_item(HEADER_BYTE, 10'($urandom));
		for (int i = 1; i < REQ_LEN - 1; i++) begin
			if (i == 5) send_item(cmd, 10'($urandom));
			else if (i == 6) send_item(sub, 10'($urandom));
			else send_item(8'($urandom), 10'($urandom));
		end
		send_item(8'($urandom), adc);
	endtask

	task automatic drain();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (track.pending_bytes.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		drain();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		track.write_reg(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [9:0] pick_adc();
		if ($urandom_range(1)) return 10'($urandom_range(757, 450));
		return 10'($urandom);
	endfunction

	function automatic logic [7:0] pick_cmd();
		case ($urandom_range(8))
			0: return CMD_SERIAL;
			1: return CMD_CYCLES;
			2: return CMD_DATE;
			3, 7: return CMD_STAT30;
			4, 8: return CMD_STAT31;
			5: return CMD_PING;
			default: return ($urandom_range(1)) ? CMD_CELLS : 8'($urandom);
		endcase
	endfunction

	task automatic random_run(int items, bit hold_off);
		int sent;
		logic [7:0] noise;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(9) == 0) begin
				noise = 8'($urandom);
				if (noise == HEADER_BYTE) noise = ~noise;
				send_item(noise, 10'($urandom));
				sent++;
			end else begin
				if (hold_off && $urandom_range(3) == 0) begin
					@(negedge clk);
					in_ch.valid = 1'b0;
					while (track.pending_bytes.size() != 0) @(posedge clk);
				end
				send_request(pick_cmd(),
					($urandom_range(1)) ? SUB_SHORT_SERIAL : 8'($urandom), pick_adc());
				sent += REQ_LEN;
			end
		end
	endtask

	initial begin
		track = new();
		send_idle = 0;
		recv_stall = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_PACK_CAPACITY;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.rx_byte = '0;
		in_ch.adc_sample = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_item(8'h00, 10'h000);
		send_item(8'hFF, 10'h3FF);
		send_request(CMD_SERIAL, SUB_SHORT_SERIAL, 10'h000);
		send_request(CMD_SERIAL, 8'hFF, 10'h3FF);
		send_request(CMD_STAT30, 8'h00, 10'h3FF);
		send_request(CMD_STAT31, 8'h00, 10'h000);
		send_request(CMD_CELLS, 8'h00, 10'h3FF);
		send_request(CMD_CELLS, 8'h00, 10'h000);
		send_request(CMD_PING, 8'h00, 10'h155);
		send_request(CMD_CYCLES, 8'h00, 10'h2AA);
		send_request(CMD_DATE, 8'h00, 10'h200);
		send_request(8'hFF, 8'h00, 10'h100);
		random_run(70, 1'b0);

		write_reg(CFG_PACK_CAPACITY, 16'd0);
		write_reg(CFG_SMOOTHING_LIMIT, 16'd1);
		send_idle = 50;
		random_run(70, 1'b1);

		write_reg(CFG_PACK_CAPACITY, 16'hFFFF);
		write_reg(CFG_SMOOTHING_LIMIT, 16'd64);
		send_idle = 0;
		recv_stall = 50;
		random_run(70, 1'b0);

		write_reg(CFG_PACK_CAPACITY, 16'($urandom));
		write_reg(CFG_SMOOTHING_LIMIT, 16'd0);
		send_idle = 8;
		recv_stall = 8;
		random_run(30, 1'b0);
		write_reg(CFG_SMOOTHING_LIMIT, 16'd3);
		random_run(30, 1'b1);

		drain();
		if (track.errors == 0 && track.pending_bytes.size() == 0)
			$display("battery_status_responder_core: match");
		else
			$display("battery_status_responder_core: mismatch");
		$finish;
	end
endmodule
